@@ rtl/rlcc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB lamp colour controller package
// Shared types, mode codes, colour wheel constants and the party colour ROM.
// ----------------------------------------------------------------------------
package rlcc_pkg;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_POT   = 2'd0;
	localparam mode_t MODE_NIGHT = 2'd1;
	localparam mode_t MODE_PARTY = 2'd2;

	// Colour wheel segment limits on the pot level.
	localparam logic [7:0] POT_LOW_END   = 8'd30;
	localparam logic [7:0] POT_RED_END   = 8'd85;
	localparam logic [7:0] POT_GREEN_END = 8'd170;
	localparam logic [7:0] POT_BLUE_END  = 8'd240;
	localparam logic [7:0] POT_HOLD_END  = 8'd250;
	localparam logic [7:0] DUTY_FULL     = 8'd255;
	localparam logic [7:0] LOW_GREEN     = 8'd100;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Party colour ROM. Entries past the defined colours are black.
	function automatic rgb_t colour_rom(input logic [4:0] idx);
		rgb_t c;
		c = '{r: 8'd0, g: 8'd0, b: 8'd0};
		case (idx)
			5'd0:  c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			5'd1:  c = '{r: 8'd232, g: 8'd12,  b: 8'd122};
			5'd2:  c = '{r: 8'd253, g: 8'd13,  b: 8'd255};
			5'd3:  c = '{r: 8'd167, g: 8'd0,   b: 8'd232};
			5'd4:  c = '{r: 8'd114, g: 8'd0,   b: 8'd255};
			5'd5:  c = '{r: 8'd50,  g: 8'd12,  b: 8'd232};
			5'd6:  c = '{r: 8'd13,  g: 8'd36,  b: 8'd255};
			5'd7:  c = '{r: 8'd0,   g: 8'd83,  b: 8'd232};
			5'd8:  c = '{r: 8'd0,   g: 8'd159, b: 8'd255};
			5'd9:  c = '{r: 8'd12,  g: 8'd207, b: 8'd232};
			5'd10: c = '{r: 8'd12,  g: 8'd207, b: 8'd232};
			5'd11: c = '{r: 8'd13,  g: 8'd255, b: 8'd216};
			5'd12: c = '{r: 8'd0,   g: 8'd232, b: 8'd129};
			5'd13: c = '{r: 8'd0,   g: 8'd255, b: 8'd70};
			5'd14: c = '{r: 8'd14,  g: 8'd232, b: 8'd12};
			5'd15: c = '{r: 8'd100, g: 8'd255, b: 8'd13};
			5'd16: c = '{r: 8'd164, g: 8'd232, b: 8'd0};
			5'd17: c = '{r: 8'd255, g: 8'd251, b: 8'd0};
			5'd18: c = '{r: 8'd232, g: 8'd206, b: 8'd12};
			5'd19: c = '{r: 8'd255, g: 8'd202, b: 8'd13};
			5'd20: c = '{r: 8'd232, g: 8'd158, b: 8'd0};
			5'd21: c = '{r: 8'd255, g: 8'd147, b: 8'd0};
			5'd22: c = '{r: 8'd232, g: 8'd107, b: 8'd12};
			5'd23: c = '{r: 8'd255, g: 8'd82,  b: 8'd13};
			5'd24: c = '{r: 8'd232, g: 8'd34,  b: 8'd1};
			default: c = '{r: 8'd0, g: 8'd0, b: 8'd0};
		endcase
		return c;
	endfunction

	// One step of a duty toward its target.
	function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt);
		logic [7:0] nxt;
		nxt = cur;
		if (cur < tgt) begin
			nxt = cur + 8'd1;
		end else if (cur > tgt) begin
			nxt = cur - 8'd1;
		end
		return nxt;
	endfunction

endpackage

@@ rtl/rgb_lamp_colour_controller_unit.sv @@
// ----------------------------------------------------------------------------
// RGB lamp colour controller
// Per-tick update of the red, green and blue PWM duties from a mode and a
// potentiometer level, with a colour wheel, a night red and a party fade.
// ----------------------------------------------------------------------------
// Each accepted request is one tick. The block takes one request per clock
// cycle for as long as results are taken. A request sits in the input
// register while the combinational update runs, and the result is offered
// once the update has written the duty registers; a full result register
// that is not taken holds the request in the input register. The duty
// registers are the lamp state itself, so the state update loop from duty
// registers back to the next tick's logic sets the rate at one tick per
// cycle. While the result register is full and not taken, the input register
// still takes one further request, and then the request side stalls. The
// fade_entry output gives the party table position after the tick in every
// mode; it only moves in party mode. TABLE_ENTRIES sets how many ROM colours
// the party fade cycles through before wrapping to the first one.
// ----------------------------------------------------------------------------
module rgb_lamp_colour_controller_unit
	import rlcc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] mode,
	input  logic [7:0] pot_level,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] red_duty,
	output logic [7:0] green_duty,
	output logic [7:0] blue_duty,
	output logic [4:0] fade_entry
);

	localparam logic [5:0] LAST_ENTRY = 6'(TABLE_ENTRIES);

	// Input register stage.
	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] pot_s1;

	// Lamp state, which doubles as the result register.
	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;
	logic [4:0] table_pos_q;
	mode_t      prev_mode_q;

	logic advance;
	logic take_in;

	// The update fires when a request sits in the input register and the
	// result slot is free or is being emptied this cycle.
	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign take_in    = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1 <= mode;
			pot_s1  <= pot_level;
		end
	end

	// Colour wheel. Each ramp subtracts its segment start, then triples the
	// offset; the offset is at most 85, so the triple stays within 255.
	logic [7:0] seg_base;
	logic [7:0] seg_off;
	logic [9:0] seg_triple;
	logic [7:0] ramp;
	rgb_t       wheel;
	logic       wheel_hold;

	always_comb begin
		if (pot_s1 <= POT_RED_END) begin
			seg_base = 8'd0;
		end else if (pot_s1 <= POT_GREEN_END) begin
			seg_base = POT_RED_END;
		end else begin
			seg_base = POT_GREEN_END;
		end
		seg_off    = pot_s1 - seg_base;
		seg_triple = {2'b00, seg_off} + {1'b0, seg_off, 1'b0};
		ramp       = 8'(10'(DUTY_FULL) - seg_triple);
	end

	always_comb begin
		wheel      = '{r: red_q, g: green_q, b: blue_q};
		wheel_hold = 1'b0;
		if (pot_s1 <= POT_LOW_END) begin
			wheel = '{r: DUTY_FULL, g: LOW_GREEN, b: 8'd0};
		end else if (pot_s1 <= POT_RED_END) begin
			wheel = '{r: ramp, g: DUTY_FULL - ramp, b: 8'd0};
		end else if (pot_s1 <= POT_GREEN_END) begin
			wheel = '{r: 8'd0, g: ramp, b: DUTY_FULL - ramp};
		end else if (pot_s1 <= POT_BLUE_END) begin
			wheel = '{r: DUTY_FULL - ramp, g: 8'd0, b: ramp};
		end else if (pot_s1 >= POT_HOLD_END) begin
			wheel = '{r: DUTY_FULL, g: 8'd0, b: 8'd0};
		end else begin
			// Between the blue ramp and full red the colour is held.
			wheel_hold = 1'b1;
		end
	end

	// Party fade. On entry into party mode the duties start from zero.
	rgb_t       fade_start;
	rgb_t       fade_target;
	rgb_t       fade;
	logic       fade_hit;
	logic [5:0] pos_inc;
	logic [4:0] pos_next;

	always_comb begin
		if (prev_mode_q != MODE_PARTY) begin
			fade_start = '{r: 8'd0, g: 8'd0, b: 8'd0};
		end else begin
			fade_start = '{r: red_q, g: green_q, b: blue_q};
		end
		fade_target = colour_rom(table_pos_q);
		fade.r      = approach(fade_start.r, fade_target.r);
		fade.g      = approach(fade_start.g, fade_target.g);
		fade.b      = approach(fade_start.b, fade_target.b);
		fade_hit    = (fade == fade_target);
		pos_inc     = {1'b0, table_pos_q} + 6'd1;
		if (pos_inc >= LAST_ENTRY) begin
			pos_next = 5'd0;
		end else begin
			pos_next = pos_inc[4:0];
		end
	end

	// Next lamp state for the tick in the input register.
	rgb_t       next_rgb;
	logic [4:0] next_pos;

	always_comb begin
		next_pos = table_pos_q;
		case (mode_s1)
			MODE_PARTY: begin
				next_rgb = fade;
				if (fade_hit) begin
					next_pos = pos_next;
				end
			end
			MODE_NIGHT: begin
				next_rgb = '{r: DUTY_FULL, g: 8'd0, b: 8'd0};
			end
			default: begin
				// Pot mode, and the unused mode code, run the colour wheel.
				next_rgb = wheel;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			red_q       <= 8'd0;
			green_q     <= 8'd0;
			blue_q      <= 8'd0;
			table_pos_q <= 5'd0;
			prev_mode_q <= MODE_POT;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				red_q       <= next_rgb.r;
				green_q     <= next_rgb.g;
				blue_q      <= next_rgb.b;
				table_pos_q <= next_pos;
				prev_mode_q <= mode_s1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign red_duty     = red_q;
	assign green_duty   = green_q;
	assign blue_duty    = blue_q;
	assign fade_entry   = table_pos_q;

	// The party position never leaves the active part of the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, table_pos_q} < LAST_ENTRY)
		else $error("party table position beyond the last entry");

	// A night tick always yields pure red.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 == MODE_NIGHT |=>
		red_q == DUTY_FULL && green_q == 8'd0 && blue_q == 8'd0)
		else $error("night tick did not give pure red");

	// Without an update the lamp state holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(red_q) && $stable(green_q) && $stable(blue_q)
		&& $stable(table_pos_q) && $stable(prev_mode_q))
		else $error("lamp state changed without an update");

	// Only a party tick moves the table position.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 != MODE_PARTY |=> $stable(table_pos_q))
		else $error("table position moved outside party mode");

	// A colour wheel hold keeps the previous duties.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 != MODE_NIGHT && mode_s1 != MODE_PARTY && wheel_hold |=>
		$stable(red_q) && $stable(green_q) && $stable(blue_q))
		else $error("pot hold band changed the duties");

endmodule

@@ test/tb_rgb_lamp_colour_controller_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RGB lamp colour controller
// Sends mode and pot level requests through the input handshake, predicts the
// red, green and blue duties and the party table entry of every tick, and
// compares each result the block returns with the oldest prediction. Both
// sides of the block idle at random in several phases, and one phase holds
// off the result side long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_rgb_lamp_colour_controller_unit;
	import rlcc_pkg::*;

	// The party fade cycles through the full colour ROM.
	localparam int TABLE_ENTRIES = 25;

	// Mode value that the block does not name. It must act like pot mode.
	localparam mode_t MODE_SPARE = 2'd3;

	// Run limits.
	localparam int CYCLE_LIMIT      = 200000;
	localparam int HOLD_OFF_CYCLES  = 60;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RESET_CYCLES     = 12;
	localparam int FULL_SWEEP_TICKS = 200;
	localparam int MIXED_TICKS      = 80;

	// Pacing of the two handshakes.
	typedef enum logic [2:0] {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH,
		PACE_HOLD_OFF
	} pace_t;

	// One request: the mode and the pot sample of one tick.
	typedef struct {
		mode_t      mode_sel;
		logic [7:0] level;
	} lamp_tick_t;

	// One result: the duties and table entry after a tick.
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [4:0] entry;
	} lamp_result_t;

	// Block ports. Every input has a known value from time zero.
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	logic [1:0] mode         = 2'd0;
	logic [7:0] pot_level    = 8'd0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] red_duty;
	logic [7:0] green_duty;
	logic [7:0] blue_duty;
	logic [4:0] fade_entry;

	// Requests waiting to be offered, and predictions waiting for results.
	lamp_tick_t   pending_ticks[$];
	lamp_result_t expected_duties[$];

	// Predicted lamp state, updated once per accepted request.
	logic [7:0] lamp_red    = 8'd0;
	logic [7:0] lamp_green  = 8'd0;
	logic [7:0] lamp_blue   = 8'd0;
	logic [4:0] party_slot  = 5'd0;
	mode_t      last_mode   = MODE_POT;

	pace_t pace          = PACE_FREE;
	int    idle_pct      = 0;
	int    stall_pct     = 0;
	logic  receiver_hold = 1'b0;
	logic  tick_taken    = 1'b0;
	int    cycle_count   = 0;
	int    mismatch_count = 0;

	rgb_lamp_colour_controller_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.pot_level(pot_level),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.red_duty(red_duty),
		.green_duty(green_duty),
		.blue_duty(blue_duty),
		.fade_entry(fade_entry)
	);

	// 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Party colors as {red, green, blue}. Slots past the defined colors are black.
	function automatic logic [23:0] party_colour(input logic [4:0] slot);
		logic [23:0] rgb;
		case (slot)
			5'd0:    rgb = {8'd255, 8'd0,   8'd0};
			5'd1:    rgb = {8'd232, 8'd12,  8'd122};
			5'd2:    rgb = {8'd253, 8'd13,  8'd255};
			5'd3:    rgb = {8'd167, 8'd0,   8'd232};
			5'd4:    rgb = {8'd114, 8'd0,   8'd255};
			5'd5:    rgb = {8'd50,  8'd12,  8'd232};
			5'd6:    rgb = {8'd13,  8'd36,  8'd255};
			5'd7:    rgb = {8'd0,   8'd83,  8'd232};
			5'd8:    rgb = {8'd0,   8'd159, 8'd255};
			5'd9:    rgb = {8'd12,  8'd207, 8'd232};
			5'd10:   rgb = {8'd12,  8'd207, 8'd232};
			5'd11:   rgb = {8'd13,  8'd255, 8'd216};
			5'd12:   rgb = {8'd0,   8'd232, 8'd129};
			5'd13:   rgb = {8'd0,   8'd255, 8'd70};
			5'd14:   rgb = {8'd14,  8'd232, 8'd12};
			5'd15:   rgb = {8'd100, 8'd255, 8'd13};
			5'd16:   rgb = {8'd164, 8'd232, 8'd0};
			5'd17:   rgb = {8'd255, 8'd251, 8'd0};
			5'd18:   rgb = {8'd232, 8'd206, 8'd12};
			5'd19:   rgb = {8'd255, 8'd202, 8'd13};
			5'd20:   rgb = {8'd232, 8'd158, 8'd0};
			5'd21:   rgb = {8'd255, 8'd147, 8'd0};
			5'd22:   rgb = {8'd232, 8'd107, 8'd12};
			5'd23:   rgb = {8'd255, 8'd82,  8'd13};
			5'd24:   rgb = {8'd232, 8'd34,  8'd1};
			default: rgb = 24'd0;
		endcase
		return rgb;
	endfunction

	// Moves a duty one count toward its target, or leaves it if it is there.
	function automatic logic [7:0] step_toward(input logic [7:0] now, input logic [7:0] goal);
		if (now < goal) begin
			return now + 8'd1;
		end else if (now > goal) begin
			return now - 8'd1;
		end
		return now;
	endfunction

	// Runs one tick of the lamp on the predicted state and returns the duties
	// that the block must show after it.
	function automatic lamp_result_t advance_lamp(input mode_t sel, input logic [7:0] level);
		lamp_result_t res;
		logic [23:0]  goal;
		int           lv;
		lv = int'(level);
		if (sel == MODE_PARTY) begin
			// Entering party mode starts the fade from black, but the table
			// position carries over from the last party run.
			if (last_mode != MODE_PARTY) begin
				lamp_red   = 8'd0;
				lamp_green = 8'd0;
				lamp_blue  = 8'd0;
			end
			goal       = party_colour(party_slot);
			lamp_red   = step_toward(lamp_red, goal[23:16]);
			lamp_green = step_toward(lamp_green, goal[15:8]);
			lamp_blue  = step_toward(lamp_blue, goal[7:0]);
			if (lamp_red == goal[23:16] && lamp_green == goal[15:8] &&
					lamp_blue == goal[7:0]) begin
				if (int'(party_slot) + 1 >= TABLE_ENTRIES) begin
					party_slot = 5'd0;
				end else begin
					party_slot = party_slot + 5'd1;
				end
			end
		end else if (sel == MODE_NIGHT) begin
			lamp_red   = 8'd255;
			lamp_green = 8'd0;
			lamp_blue  = 8'd0;
		end else begin
			// Pot mode and the unused mode value walk the color wheel.
			if (lv <= 30) begin
				lamp_red   = 8'd255;
				lamp_green = 8'd100;
				lamp_blue  = 8'd0;
			end else if (lv <= 85) begin
				lamp_red   = 8'(255 - 3 * lv);
				lamp_green = 8'd255 - lamp_red;
				lamp_blue  = 8'd0;
			end else if (lv <= 170) begin
				lamp_green = 8'(255 - 3 * (lv - 85));
				lamp_blue  = 8'd255 - lamp_green;
				lamp_red   = 8'd0;
			end else if (lv <= 240) begin
				lamp_blue  = 8'(255 - 3 * (lv - 170));
				lamp_red   = 8'd255 - lamp_blue;
				lamp_green = 8'd0;
			end else if (lv >= 250) begin
				lamp_red   = 8'd255;
				lamp_green = 8'd0;
				lamp_blue  = 8'd0;
			end
			// Levels 241 to 249 keep whatever color the lamp had.
		end
		last_mode = sel;
		res.red   = lamp_red;
		res.green = lamp_green;
		res.blue  = lamp_blue;
		res.entry = party_slot;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Request side. A new request goes out at the falling edge once the last
	// one was taken, unless the sender chooses to idle this cycle. Valid and
	// payload stay put while a request waits for ready.
	always @(negedge clk) begin : tick_sender
		lamp_tick_t next_tick;
		if (!item_valid || tick_taken) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_tick = pending_ticks.pop_front();
				item_valid <= 1'b1;
				mode       <= next_tick.mode_sel;
				pot_level  <= next_tick.level;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result side. During the hold-off the receiver refuses every result so
	// the block fills up and pushes back on requests.
	always @(negedge clk) begin : result_taker
		if (receiver_hold) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Both handshakes are sampled at the rising edge. A result is checked
	// before the request of the same edge is predicted, so a result can never
	// be matched against a prediction made in the same cycle.
	always @(posedge clk) begin : lamp_monitor
		lamp_result_t want;
		if (result_valid && result_ready) begin
			if (expected_duties.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: %0d %0d %0d entry %0d",
					red_duty, green_duty, blue_duty, fade_entry));
			end else begin
				want = expected_duties.pop_front();
				if (red_duty !== want.red) begin
					report_mismatch($sformatf("red_duty %0d, expected %0d", red_duty, want.red));
				end
				if (green_duty !== want.green) begin
					report_mismatch($sformatf("green_duty %0d, expected %0d",
						green_duty, want.green));
				end
				if (blue_duty !== want.blue) begin
					report_mismatch($sformatf("blue_duty %0d, expected %0d", blue_duty, want.blue));
				end
				if (fade_entry !== want.entry) begin
					report_mismatch($sformatf("fade_entry %0d, expected %0d",
						fade_entry, want.entry));
				end
			end
		end
		if (item_valid && item_ready) begin
			expected_duties.push_back(advance_lamp(mode, pot_level));
		end
		tick_taken <= item_valid && item_ready;
	end

	// The long receiver hold-off runs in its own process. It starts on the
	// edge after the hold-off phase begins, while requests are still queued.
	initial begin : receiver_hold_off
		wait (pace == PACE_HOLD_OFF);
		@(posedge clk);
		receiver_hold = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		receiver_hold = 1'b0;
	end

	// A hung block ends the run here.
	initial begin : watchdog
		wait (cycle_count == CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	task automatic queue_tick(input mode_t sel, input logic [7:0] level);
		lamp_tick_t t;
		t.mode_sel = sel;
		t.level    = level;
		pending_ticks.push_back(t);
	endtask

	// Pot levels near the wheel segment limits find most of the arithmetic
	// slips, so about half the pot samples land there.
	function automatic logic [7:0] pot_sample();
		case ($urandom_range(23))
			0:       return 8'd0;
			1:       return 8'd30;
			2:       return 8'd31;
			3:       return 8'd85;
			4:       return 8'd86;
			5:       return 8'd170;
			6:       return 8'd171;
			7:       return 8'd240;
			8:       return 8'd241;
			9:       return 8'd249;
			10:      return 8'd250;
			11:      return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly party runs of fade steps, broken up by pot samples, night red and
	// the unused mode value.
	task automatic queue_mixed_ticks(input int count);
		int queued;
		int run;
		int pick;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				run = $urandom_range(90, 8);
				repeat (run) queue_tick(MODE_PARTY, 8'($urandom_range(255)));
				queued += run;
			end else if (pick < 80) begin
				queue_tick(MODE_POT, pot_sample());
				queued++;
			end else if (pick < 90) begin
				queue_tick(MODE_NIGHT, 8'($urandom_range(255)));
				queued++;
			end else begin
				queue_tick(MODE_SPARE, pot_sample());
				queued++;
			end
		end
	endtask

	task automatic set_pace(input pace_t p);
		pace = p;
		case (p)
			PACE_SENDER_IDLE: begin
				idle_pct  = 73;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				idle_pct  = 0;
				stall_pct = 73;
			end
			PACE_BOTH: begin
				idle_pct  = 33;
				stall_pct = 33;
			end
			default: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Waits until every queued request is taken and every result is back.
	task automatic drain();
		while (pending_ticks.size() != 0 || item_valid || expected_duties.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed ticks: every wheel segment limit, the hold band after pot,
		// night and party colors, the unused mode value, party entry and
		// re-entry.
		set_pace(PACE_FREE);
		queue_tick(MODE_POT, 8'd0);
		queue_tick(MODE_POT, 8'd30);
		queue_tick(MODE_POT, 8'd31);
		queue_tick(MODE_POT, 8'd85);
		queue_tick(MODE_POT, 8'd86);
		queue_tick(MODE_POT, 8'd170);
		queue_tick(MODE_POT, 8'd171);
		queue_tick(MODE_POT, 8'd240);
		queue_tick(MODE_POT, 8'd241);
		queue_tick(MODE_POT, 8'd249);
		queue_tick(MODE_POT, 8'd250);
		queue_tick(MODE_POT, 8'd255);
		queue_tick(MODE_NIGHT, 8'd128);
		queue_tick(MODE_POT, 8'd245);
		queue_tick(MODE_SPARE, 8'd128);
		queue_tick(MODE_PARTY, 8'd0);
		queue_tick(MODE_PARTY, 8'd255);
		queue_tick(MODE_PARTY, 8'd85);
		queue_tick(MODE_POT, 8'd247);
		queue_tick(MODE_NIGHT, 8'd0);
		queue_tick(MODE_PARTY, 8'd170);
		queue_tick(MODE_SPARE, 8'd200);
		drain();

		// One unbroken party run from black, fading toward the table color at the
		// current party position.
		queue_tick(MODE_NIGHT, 8'd0);
		repeat (FULL_SWEEP_TICKS) queue_tick(MODE_PARTY, 8'($urandom_range(255)));
		drain();

		// Random traffic under each pacing.
		set_pace(PACE_FREE);
		queue_mixed_ticks(MIXED_TICKS);
		drain();
		set_pace(PACE_SENDER_IDLE);
		queue_mixed_ticks(MIXED_TICKS);
		drain();
		set_pace(PACE_RECEIVER_STALL);
		queue_mixed_ticks(MIXED_TICKS);
		drain();
		set_pace(PACE_BOTH);
		queue_mixed_ticks(MIXED_TICKS);
		drain();

		// Results are refused for a long stretch while requests keep coming.
		set_pace(PACE_HOLD_OFF);
		queue_mixed_ticks(40);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rlcc_pkg.sv
rtl/rgb_lamp_colour_controller_unit.sv
test/tb_rgb_lamp_colour_controller_unit.sv
